[hw/rtl/medb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// medb_pkg
// Shared types and sizes for the mesh edge dedup builder.
// ----------------------------------------------------------------------------
package medb_pkg;

	localparam int MAX_VERTICES  = 4096;
	localparam int MAX_EDGES     = 16384;
	localparam int MAX_TRIANGLES = 8192;

	localparam int VTX_W  = $clog2(MAX_VERTICES);
	localparam int EDGE_W = $clog2(MAX_EDGES);
	localparam int CNT_W  = EDGE_W + 1;
	localparam int TRI_W  = $clog2(MAX_TRIANGLES);

	typedef logic [VTX_W-1:0]  vtx_t;
	typedef logic [EDGE_W-1:0] edge_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TRI_W-1:0]  tri_t;

	localparam cnt_t EDGE_LIMIT = CNT_W'(MAX_EDGES);
	localparam vtx_t VTX_LAST   = VTX_W'(MAX_VERTICES - 1);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_THIRD = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-vertex chain head
	typedef struct packed {
		logic  ok;
		edge_t idx;
	} head_entry_t;

	// one stored edge
	typedef struct packed {
		vtx_t  end0;
		vtx_t  end1;
		tri_t  owner1;
		tri_t  owner2;
		logic  owner2_ok;
		logic  next_ok;
		edge_t next_idx;
	} edge_word_t;

	typedef struct packed {
		logic [11:0] vertex_a;
		logic [11:0] vertex_b;
		logic [11:0] vertex_c;
	} tri_item_t;

	typedef struct packed {
		logic [13:0] side0_edge;
		logic        side0_reversed;
		logic [13:0] side1_edge;
		logic        side1_reversed;
		logic [13:0] side2_edge;
		logic        side2_reversed;
		logic [14:0] new_edge_total;
		logic [1:0]  status;
	} res_item_t;

	typedef struct packed {
		logic start;
		vtx_t p;
		vtx_t q;
		tri_t tnum;
	} side_req_t;

	typedef struct packed {
		logic    done;
		edge_t   edge_idx;
		logic    rev;
		status_t st;
	} side_resp_t;

	typedef enum logic [2:0] {
		E_CLEAR,
		E_IDLE,
		E_HCHK,
		E_ECHK,
		E_MAKE,
		E_LINK
	} eng_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GO,
		S_WAIT,
		S_EMIT
	} seq_state_t;

endpackage
`default_nettype wire

[hw/rtl/medb_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// medb_if
// Valid/ready channels for triangle items and result items.
// ----------------------------------------------------------------------------
interface medb_tri_if;
	import medb_pkg::*;
	logic      valid;
	logic      ready;
	tri_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface medb_res_if;
	import medb_pkg::*;
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/mesh_edge_dedup_builder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_edge_dedup_builder
// Builds a deduplicated edge list from a stream of counter-clockwise triangles.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry vertex head table, one entry a
// cycle, and accepts no triangle until the sweep is done. Each triangle then
// runs its three sides, (b,c), (c,a), (a,b), one after another through a
// single chain walker that owns the head and edge memories; each memory has
// one registered read per cycle, so a side costs one chain entry per cycle.
// A side reads the head of the smaller vertex's chain and then visits chain
// entries up to and including a match; a side that finds no match appends a
// new edge unless the table is full, linked behind the chain tail if there is
// one. A triangle is taken, runs its three sides and then loads the result
// register. A result waiting in the output register does not stop the next
// triangle being taken, but that triangle's result is held until the
// register drains.
// ----------------------------------------------------------------------------
module mesh_edge_dedup_builder (
	input  logic        clk,
	input  logic        arst_n,
	medb_tri_if.sink    triangle,
	medb_res_if.source  result
);
	import medb_pkg::*;

	seq_state_t  st_q, st_d;
	tri_item_t   tri_q;
	logic [1:0]  side_q;
	tri_t        tnum_q;
	edge_t       edge_q [3];
	logic        rev_q [3];
	status_t     worst_q;
	logic        res_valid_q;
	res_item_t   res_q;

	side_req_t   req;
	side_resp_t  resp;
	logic        eng_idle;
	cnt_t        edge_total;

	logic        accept;
	logic        emit_ok;
	vtx_t        side_p, side_q_vtx;
	status_t     worst_d;

	medb_side_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.resp       (resp),
		.idle       (eng_idle),
		.edge_total (edge_total)
	);

	assign accept  = triangle.valid && triangle.ready;
	assign emit_ok = !res_valid_q || result.ready;

	// endpoints of the side opposite vertex side_q
	always_comb begin
		case (side_q)
			2'd0: begin
				side_p     = tri_q.vertex_b;
				side_q_vtx = tri_q.vertex_c;
			end
			2'd1: begin
				side_p     = tri_q.vertex_c;
				side_q_vtx = tri_q.vertex_a;
			end
			default: begin
				side_p     = tri_q.vertex_a;
				side_q_vtx = tri_q.vertex_b;
			end
		endcase
	end

	// table full outranks a third match
	always_comb begin
		worst_d = worst_q;
		if (resp.st == ST_FULL) worst_d = ST_FULL;
		else if (resp.st == ST_THIRD && worst_q == ST_OK) worst_d = ST_THIRD;
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (accept) st_d = S_GO;
			end
			S_GO: begin
				st_d = S_WAIT;
			end
			S_WAIT: begin
				if (resp.done) st_d = (side_q == 2'd2) ? S_EMIT : S_GO;
			end
			S_EMIT: begin
				if (emit_ok) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		triangle.ready = (st_q == S_IDLE) && eng_idle;
		req.start      = (st_q == S_GO);
		req.p          = side_p;
		req.q          = side_q_vtx;
		req.tnum       = tnum_q;
		result.valid   = res_valid_q;
		result.data    = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			side_q      <= '0;
			tnum_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (accept) side_q <= '0;
			else if (st_q == S_WAIT && resp.done) side_q <= side_q + 1'b1;
			if (st_q == S_EMIT && emit_ok) begin
				res_valid_q <= 1'b1;
				tnum_q      <= tnum_q + 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tri_q   <= triangle.data;
			worst_q <= ST_OK;
		end
		if (st_q == S_WAIT && resp.done) begin
			edge_q[side_q] <= resp.edge_idx;
			rev_q[side_q]  <= resp.rev;
			worst_q        <= worst_d;
		end
		if (st_q == S_EMIT && emit_ok) begin
			res_q.side0_edge     <= edge_q[0];
			res_q.side0_reversed <= rev_q[0];
			res_q.side1_edge     <= edge_q[1];
			res_q.side1_reversed <= rev_q[1];
			res_q.side2_edge     <= edge_q[2];
			res_q.side2_reversed <= rev_q[2];
			res_q.new_edge_total <= edge_total;
			res_q.status         <= worst_q;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !triangle.ready)
		else $error("item taken while previous triangle in flight");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		resp.done |-> (st_q == S_WAIT))
		else $error("side response outside wait state");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EMIT && emit_ok) |=> res_valid_q)
		else $error("result register not loaded on emit");

endmodule
`default_nettype wire

[hw/rtl/medb_side_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// medb_side_engine
// Chain walker for one triangle side: owns the head and edge memories,
// searches the smaller vertex's chain and matches or appends the edge.
// ----------------------------------------------------------------------------
module medb_side_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  medb_pkg::side_req_t    req,
	output medb_pkg::side_resp_t   resp,
	output logic                   idle,
	output medb_pkg::cnt_t         edge_total
);
	import medb_pkg::*;

	eng_state_t  state_q, state_d;
	vtx_t        clr_q;
	cnt_t        cnt_q;

	vtx_t        p_q, q_q, lo_q, hi_q;
	logic        swp_q;
	tri_t        tnum_q;
	edge_t       cur_q, last_q, new_q;
	logic        has_last_q;

	head_entry_t head_mem [MAX_VERTICES];
	head_entry_t head_rd_q;
	logic        head_we, head_re;
	vtx_t        head_wa, head_ra;
	head_entry_t head_wd;

	edge_word_t  edge_mem [MAX_EDGES];
	edge_word_t  edge_rd_q;
	logic        edge_we, edge_re;
	edge_t       edge_wa, edge_ra;
	edge_word_t  edge_wd;

	vtx_t        req_lo;
	vtx_t        probe;
	logic        hit;
	logic        full;
	edge_t       slot;

	assign req_lo = (req.q > req.p) ? req.p : req.q;
	assign probe  = swp_q ? edge_rd_q.end1 : edge_rd_q.end0;
	assign hit    = (probe == hi_q);
	assign full   = (cnt_q == EDGE_LIMIT);
	assign slot   = cnt_q[EDGE_W-1:0];

	assign idle       = (state_q == E_IDLE);
	assign edge_total = cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			E_CLEAR: begin
				if (clr_q == VTX_LAST) state_d = E_IDLE;
			end
			E_IDLE: begin
				if (req.start) state_d = E_HCHK;
			end
			E_HCHK: begin
				state_d = head_rd_q.ok ? E_ECHK : E_MAKE;
			end
			E_ECHK: begin
				if (hit) state_d = E_IDLE;
				else if (!edge_rd_q.next_ok) state_d = E_MAKE;
			end
			E_MAKE: begin
				state_d = (full || !has_last_q) ? E_IDLE : E_LINK;
			end
			E_LINK: begin
				state_d = E_IDLE;
			end
			default: state_d = E_IDLE;
		endcase
	end

	// memory controls and side response
	always_comb begin
		head_we = 1'b0;
		head_re = 1'b0;
		head_wa = '0;
		head_ra = '0;
		head_wd = '0;
		edge_we = 1'b0;
		edge_re = 1'b0;
		edge_wa = '0;
		edge_ra = '0;
		edge_wd = edge_rd_q;
		resp    = '0;
		resp.st = ST_OK;
		case (state_q)
			E_CLEAR: begin
				head_we = 1'b1;
				head_wa = clr_q;
			end
			E_IDLE: begin
				head_re = req.start;
				head_ra = req_lo;
			end
			E_HCHK: begin
				edge_re = head_rd_q.ok;
				edge_ra = head_rd_q.idx;
			end
			E_ECHK: begin
				if (hit) begin
					resp.done     = 1'b1;
					resp.edge_idx = cur_q;
					resp.rev      = 1'b1;
					if (edge_rd_q.owner2_ok) begin
						resp.st = ST_THIRD;
					end else begin
						edge_we           = 1'b1;
						edge_wa           = cur_q;
						edge_wd.owner2    = tnum_q;
						edge_wd.owner2_ok = 1'b1;
					end
				end else if (edge_rd_q.next_ok) begin
					edge_re = 1'b1;
					edge_ra = edge_rd_q.next_idx;
				end
			end
			E_MAKE: begin
				if (full) begin
					resp.done = 1'b1;
					resp.st   = ST_FULL;
				end else begin
					edge_we = 1'b1;
					edge_wa = slot;
					edge_wd = '{end0: p_q, end1: q_q, owner1: tnum_q, owner2: '0,
						owner2_ok: 1'b0, next_ok: 1'b0, next_idx: '0};
					if (!has_last_q) begin
						head_we       = 1'b1;
						head_wa       = lo_q;
						head_wd       = '{ok: 1'b1, idx: slot};
						resp.done     = 1'b1;
						resp.edge_idx = slot;
					end
				end
			end
			E_LINK: begin
				// tail of the chain still sits in the read register
				edge_we          = 1'b1;
				edge_wa          = last_q;
				edge_wd.next_ok  = 1'b1;
				edge_wd.next_idx = new_q;
				resp.done        = 1'b1;
				resp.edge_idx    = new_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == E_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == E_MAKE && !full) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				if (req.start) begin
					p_q        <= req.p;
					q_q        <= req.q;
					lo_q       <= req_lo;
					hi_q       <= (req.q > req.p) ? req.q : req.p;
					swp_q      <= !(req.q > req.p);
					tnum_q     <= req.tnum;
					has_last_q <= 1'b0;
				end
			end
			E_HCHK: begin
				cur_q <= head_rd_q.idx;
			end
			E_ECHK: begin
				if (!hit) begin
					if (edge_rd_q.next_ok) begin
						cur_q <= edge_rd_q.next_idx;
					end else begin
						last_q     <= cur_q;
						has_last_q <= 1'b1;
					end
				end
			end
			E_MAKE: begin
				new_q <= slot;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		if (head_re) head_rd_q <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_wa] <= edge_wd;
		if (edge_re) edge_rd_q <= edge_mem[edge_ra];
	end

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (state_q == E_IDLE))
		else $error("side start while engine busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= EDGE_LIMIT)
		else $error("edge count past table size");

	a_edge_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(edge_we && edge_re))
		else $error("edge memory read and write in one cycle");

	a_link_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_LINK) |-> (last_q != new_q))
		else $error("chain tail linked to itself");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_MAKE && !full) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("edge count not advanced on append");

endmodule
`default_nettype wire

[verif/tb_mesh_edge_dedup_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_edge_dedup_builder
// Self-checking bench for the mesh edge dedup builder. Triangles go in over
// the valid/ready channel, each accepted item is run through a local copy of
// the edge chains, and every result item is compared field by field with the
// oldest prediction. Directed corner cases first, then random mesh patches
// with noise, and finally a stretch with no idling.
// ----------------------------------------------------------------------------
module tb_mesh_edge_dedup_builder;
	import medb_pkg::*;

	localparam int CYCLE_LIMIT  = 3000000;
	localparam int DRAIN_CYCLES = 64;
	localparam int MESH_ITEMS   = 380;
	localparam int STEADY_ITEMS = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	medb_tri_if tri_ch ();
	medb_res_if res_ch ();

	mesh_edge_dedup_builder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.triangle (tri_ch),
		.result (res_ch)
	);

	always #10 clk = ~clk;

	// local copy of the edge store
	edge_t chain_head_idx [MAX_VERTICES];
	bit    chain_head_ok  [MAX_VERTICES];
	vtx_t  edge_end0      [MAX_EDGES];
	vtx_t  edge_end1      [MAX_EDGES];
	tri_t  edge_owner1    [MAX_EDGES];
	tri_t  edge_owner2    [MAX_EDGES];
	bit    edge_owner2_ok [MAX_EDGES];
	edge_t edge_next      [MAX_EDGES];
	bit    edge_next_ok   [MAX_EDGES];
	int    edges_made = 0;
	tri_t  tri_number = '0;

	res_item_t pending_results [$];
	tri_item_t recent_tris [$];
	int        items_sent = 0;
	int        mismatches = 0;
	int        cycle_count = 0;
	bit        gaps_on = 1'b1;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (!gaps_on || pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic vtx_t rand_vtx();
		return vtx_t'($urandom);
	endfunction

	function automatic tri_item_t tri_of(input vtx_t a, input vtx_t b, input vtx_t c);
		tri_item_t t;
		t.vertex_a = a;
		t.vertex_b = b;
		t.vertex_c = c;
		return t;
	endfunction

	// search the chain of the smaller vertex, claim a reversed edge or append a new one
	function automatic status_t resolve_side(input vtx_t p, input vtx_t q,
			output edge_t e, output logic rev);
		vtx_t lo, hi, probe;
		bit   swapped, have, have_tail;
		int   cur, tail_idx, steps;
		if (q > p) begin
			lo = p;
			hi = q;
			swapped = 1'b0;
		end else begin
			lo = q;
			hi = p;
			swapped = 1'b1;
		end
		have = chain_head_ok[lo];
		cur = have ? int'(chain_head_idx[lo]) : 0;
		tail_idx = 0;
		have_tail = 1'b0;
		steps = 0;
		while (have && cur < MAX_EDGES && steps < edges_made) begin
			probe = swapped ? edge_end1[cur] : edge_end0[cur];
			if (probe == hi) begin
				e = edge_t'(cur);
				rev = 1'b1;
				if (edge_owner2_ok[cur])
					return ST_THIRD;
				edge_owner2[cur] = tri_number;
				edge_owner2_ok[cur] = 1'b1;
				return ST_OK;
			end
			tail_idx = cur;
			have_tail = 1'b1;
			have = edge_next_ok[cur];
			cur = edge_next[cur];
			steps++;
		end
		if (edges_made >= MAX_EDGES) begin
			e = '0;
			rev = 1'b0;
			return ST_FULL;
		end
		cur = edges_made;
		edge_end0[cur] = p;
		edge_end1[cur] = q;
		edge_owner1[cur] = tri_number;
		edge_owner2_ok[cur] = 1'b0;
		edge_next_ok[cur] = 1'b0;
		edge_next[cur] = '0;
		if (!chain_head_ok[lo] || !have_tail) begin
			chain_head_idx[lo] = edge_t'(cur);
			chain_head_ok[lo] = 1'b1;
		end else begin
			edge_next[tail_idx] = edge_t'(cur);
			edge_next_ok[tail_idx] = 1'b1;
		end
		edges_made++;
		e = edge_t'(cur);
		rev = 1'b0;
		return ST_OK;
	endfunction

	function automatic res_item_t predict_triangle(input tri_item_t t);
		vtx_t      v [3];
		res_item_t r;
		status_t   st, worst;
		edge_t     e;
		logic      rev;
		int        j;
		v[0] = t.vertex_a;
		v[1] = t.vertex_b;
		v[2] = t.vertex_c;
		worst = ST_OK;
		r = '0;
		// sides (b,c), (c,a), (a,b)
		for (j = 0; j < 3; j++) begin
			st = resolve_side(v[(j + 1) % 3], v[(j + 2) % 3], e, rev);
			if (st == ST_FULL)
				worst = ST_FULL;
			else if (st == ST_THIRD && worst == ST_OK)
				worst = ST_THIRD;
			case (j)
				0: begin
					r.side0_edge = e;
					r.side0_reversed = rev;
				end
				1: begin
					r.side1_edge = e;
					r.side1_reversed = rev;
				end
				default: begin
					r.side2_edge = e;
					r.side2_reversed = rev;
				end
			endcase
		end
		r.new_edge_total = 15'(edges_made);
		r.status = worst;
		tri_number = tri_number + 1'b1;
		return r;
	endfunction

	// called at a clock edge; keeps valid high when there is no gap
	task automatic send_triangle(input tri_item_t t);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			tri_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tri_ch.valid <= 1'b1;
		tri_ch.data <= t;
		@(posedge clk);
		while (!tri_ch.ready)
			@(posedge clk);
		pending_results.push_back(predict_triangle(t));
		recent_tris.push_back(t);
		if (recent_tris.size() > 32)
			void'(recent_tris.pop_front());
		items_sent++;
	endtask

	task automatic check_field(input string what, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
			mismatches++;
		end
	endtask

	initial begin
		int        stall;
		res_item_t got, want;
		res_ch.ready = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got = res_ch.data;
				if (pending_results.size() == 0) begin
					$display("%0t: result item with nothing pending, expected none, actual %h",
						$time, got);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("side0_edge", want.side0_edge, got.side0_edge);
					check_field("side0_reversed", want.side0_reversed, got.side0_reversed);
					check_field("side1_edge", want.side1_edge, got.side1_edge);
					check_field("side1_reversed", want.side1_reversed, got.side1_reversed);
					check_field("side2_edge", want.side2_edge, got.side2_edge);
					check_field("side2_reversed", want.side2_reversed, got.side2_reversed);
					check_field("new_edge_total", want.new_edge_total, got.new_edge_total);
					check_field("status", want.status, got.status);
				end
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = gap_length();
			end
		end
	end

	task automatic test_corner_vertices();
		send_triangle(tri_of(12'd0, 12'd1, 12'd2));
		send_triangle(tri_of(12'd4095, 12'd4094, 12'd4093));
		send_triangle(tri_of(12'hAAA, 12'h555, 12'hFFF));
		send_triangle(tri_of(12'd4095, 12'd0, 12'd2048));
	endtask

	// second owner, same-orientation duplicate, third match, reversed copy
	task automatic test_shared_edges();
		send_triangle(tri_of(12'd100, 12'd101, 12'd201));
		send_triangle(tri_of(12'd100, 12'd201, 12'd200));
		send_triangle(tri_of(12'd201, 12'd100, 12'd300));
		send_triangle(tri_of(12'd100, 12'd201, 12'd400));
		send_triangle(tri_of(12'd100, 12'd201, 12'd101));
	endtask

	task automatic test_degenerate_sides();
		send_triangle(tri_of(12'd7, 12'd7, 12'd9));
		send_triangle(tri_of(12'd5, 12'd5, 12'd5));
		send_triangle(tri_of(12'd5, 12'd5, 12'd5));
		send_triangle(tri_of(12'd9, 12'd7, 12'd7));
		send_triangle(tri_of(12'd4095, 12'd4095, 12'd0));
	endtask

	// fan round one vertex so its chain grows
	task automatic test_vertex_fan();
		int i;
		for (i = 0; i < 6; i++)
			send_triangle(tri_of(12'd50, vtx_t'(60 + i), vtx_t'(61 + i)));
	endtask

	// a small consistently oriented grid, cells optionally shuffled and rotated
	task automatic send_patch();
		int        cols, rows, stride, base, r, c, k, j, rot;
		tri_item_t cells [$];
		tri_item_t tmp;
		vtx_t      v00, v01, v10, v11;
		cols = $urandom_range(2, 5);
		rows = $urandom_range(2, 4);
		stride = $urandom_range(cols, 400);
		base = $urandom_range(0, 4095);
		for (r = 0; r < rows - 1; r++) begin
			for (c = 0; c < cols - 1; c++) begin
				v00 = vtx_t'(base + r * stride + c);
				v01 = vtx_t'(base + r * stride + c + 1);
				v10 = vtx_t'(base + (r + 1) * stride + c);
				v11 = vtx_t'(base + (r + 1) * stride + c + 1);
				cells.push_back(tri_of(v00, v01, v11));
				cells.push_back(tri_of(v00, v11, v10));
			end
		end
		if ($urandom_range(0, 1) == 1) begin
			for (k = cells.size() - 1; k > 0; k--) begin
				j = $urandom_range(0, k);
				tmp = cells[k];
				cells[k] = cells[j];
				cells[j] = tmp;
			end
		end
		for (k = 0; k < cells.size(); k++) begin
			tmp = cells[k];
			rot = $urandom_range(0, 2);
			if (rot == 1)
				tmp = tri_of(tmp.vertex_b, tmp.vertex_c, tmp.vertex_a);
			else if (rot == 2)
				tmp = tri_of(tmp.vertex_c, tmp.vertex_a, tmp.vertex_b);
			send_triangle(tmp);
		end
	endtask

	// mostly well-formed patches, plus noise, repeats and collapsed sides
	task automatic send_mixed_item();
		int        pick;
		tri_item_t t;
		vtx_t      a, b;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			send_patch();
		end else if (pick < 78 || recent_tris.size() == 0) begin
			send_triangle(tri_of(rand_vtx(), rand_vtx(), rand_vtx()));
		end else if (pick < 90) begin
			t = recent_tris[$urandom_range(0, recent_tris.size() - 1)];
			case ($urandom_range(0, 2))
				0: send_triangle(t);
				1: send_triangle(tri_of(t.vertex_a, t.vertex_c, t.vertex_b));
				default: send_triangle(tri_of(t.vertex_c, t.vertex_b, rand_vtx()));
			endcase
		end else begin
			a = rand_vtx();
			b = ($urandom_range(0, 2) == 0) ? a : rand_vtx();
			case ($urandom_range(0, 2))
				0: send_triangle(tri_of(a, a, b));
				1: send_triangle(tri_of(a, b, a));
				default: send_triangle(tri_of(b, a, a));
			endcase
		end
	endtask

	task automatic test_mesh_patches();
		int stop_at;
		stop_at = items_sent + MESH_ITEMS;
		while (items_sent < stop_at)
			send_mixed_item();
	endtask

	task automatic test_back_to_back();
		int stop_at;
		gaps_on = 1'b0;
		stop_at = items_sent + STEADY_ITEMS;
		while (items_sent < stop_at)
			send_mixed_item();
		gaps_on = 1'b1;
	endtask

	initial begin
		tri_ch.valid = 1'b0;
		tri_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_corner_vertices();
		test_shared_edges();
		test_degenerate_sides();
		test_vertex_fan();
		test_mesh_patches();
		test_back_to_back();
		tri_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/medb_pkg.sv
hw/rtl/medb_if.sv
hw/rtl/medb_side_engine.sv
hw/rtl/mesh_edge_dedup_builder.sv
verif/tb_mesh_edge_dedup_builder.sv
